[hw/rtl/iptx_pkg.sv]
// Shared types and constants of the IPv4 transmit header generator.
`default_nettype none

package iptx_pkg;

	// APB register map: register index sits at paddr[2] (byte address 4*i).
	localparam int unsigned APB_AW = 3;
	localparam int unsigned APB_DW = 32;
	localparam logic REG_IDX_LOCAL_ADDR = 1'b0;
	localparam logic REG_IDX_DEVICE_MTU = 1'b1;

	localparam logic [13:0] MTU_RESET = 14'd1500;
	localparam logic [13:0] MTU_FLOOR = 14'd1044;
	localparam logic [13:0] HDR_BYTES_14 = 14'd20;
	localparam logic [15:0] HDR_BYTES = 16'd20;
	localparam logic [15:0] MAX_PAYLOAD = 16'd65515;
	localparam logic [13:0] CHUNK_MASK = ~14'd7;
	localparam logic [7:0] VER_IHL = {4'd4, 4'd5};

	// The header is summed as nine 16-bit words.
	localparam int unsigned WIDX_W = 4;
	localparam logic [WIDX_W-1:0] WIDX_LAST = WIDX_W'(8);

	typedef enum logic [1:0] {
		STATUS_OK = 2'd0,
		STATUS_TOO_LARGE = 2'd1,
		STATUS_DST_SELF = 2'd2,
		STATUS_NEED_FRAG_DF = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_FRAG,
		ST_SUM,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic clear;
		logic add;
	} csum_ctrl_t;

endpackage

`default_nettype wire

[hw/rtl/ipv4_tx_fragment_header_gen.sv]
// A rejected request goes from acceptance through the check state to the output state;
// otherwise each header, the first after the check state and each further one after the
// previous one is taken, passes the setup, checksum (nine words) and output states.
// The header checksum adder takes one 16-bit word per cycle while summing.
// A new request can be accepted from the cycle after the last result of the previous one is taken.
// Reset clears the sequencer and the identification counter, and restores the registers.
`default_nettype none

module ipv4_tx_fragment_header_gen (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [iptx_pkg::APB_AW-1:0]   paddr,
	input  logic [iptx_pkg::APB_DW-1:0]   pwdata,
	output logic [iptx_pkg::APB_DW-1:0]   prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [31:0]                   dst_addr,
	input  logic [7:0]                    proto,
	input  logic [15:0]                   payload_len,
	input  logic [7:0]                    hop_limit,
	input  logic [5:0]                    dscp_val,
	input  logic [1:0]                    ecn_val,
	input  logic                          dont_frag,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    status,
	output logic [15:0]                   ident,
	output logic [12:0]                   frag_offset,
	output logic                          more_frags,
	output logic                          df_flag,
	output logic [15:0]                   payload_start,
	output logic [15:0]                   frag_len,
	output logic [15:0]                   total_len,
	output logic [15:0]                   hdr_checksum,
	output logic                          last
);
	import iptx_pkg::*;

	state_t state_q, state_d;

	logic [31:0] local_addr_q;
	logic [13:0] device_mtu_q;
	logic [15:0] ident_cnt_q;

	logic [31:0] dst_q;
	logic [7:0]  proto_q;
	logic [15:0] len_q;
	logic [7:0]  ttl_q;
	logic [7:0]  tos_q;
	logic        df_q;
	logic [13:0] limit_q;
	logic        single_q;
	logic [15:0] pos_q;
	logic [WIDX_W-1:0] widx_q;

	status_t     status_q;
	logic [15:0] ident_q;
	logic [12:0] frag_off_q;
	logic        mf_q;
	logic        dff_q;
	logic [15:0] flen_q;
	logic [15:0] tot_q;
	logic        last_q;

	logic        cfg_wr;
	logic [13:0] mtu_eff;
	logic [13:0] chunk;
	logic        too_big;
	logic        is_self;
	logic        need_frag;
	logic [15:0] rem;
	logic        fits;
	logic [15:0] word;
	logic [15:0] csum_res;
	csum_ctrl_t  csum_ctrl;
	logic        in_acc;
	logic        out_acc;

	// Configuration port.
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_comb begin
		unique case (paddr[2])
			REG_IDX_LOCAL_ADDR: prdata = local_addr_q;
			REG_IDX_DEVICE_MTU: prdata = {{(APB_DW-14){1'b0}}, device_mtu_q};
			default:            prdata = '0;
		endcase
	end

	// Request checks and fragment sizing.
	assign mtu_eff = (device_mtu_q < MTU_FLOOR) ? MTU_FLOOR : device_mtu_q;
	assign chunk = limit_q & CHUNK_MASK;
	assign too_big = len_q > MAX_PAYLOAD;
	assign is_self = dst_q == local_addr_q;
	assign need_frag = len_q > {2'b00, limit_q};
	assign rem = len_q - pos_q;
	assign fits = rem <= {2'b00, chunk};

	always_comb begin
		case (widx_q)
			4'd0:    word = {VER_IHL, tos_q};
			4'd1:    word = tot_q;
			4'd2:    word = ident_q;
			4'd3:    word = {1'b0, dff_q, mf_q, frag_off_q};
			4'd4:    word = {ttl_q, proto_q};
			4'd5:    word = local_addr_q[31:16];
			4'd6:    word = local_addr_q[15:0];
			4'd7:    word = dst_q[31:16];
			default: word = dst_q[15:0];
		endcase
	end

	iptx_csum_unit u_csum (
		.clk    (clk),
		.ctrl   (csum_ctrl),
		.word   (word),
		.result (csum_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		in_stall = 1'b1;
		out_valid = 1'b0;
		csum_ctrl = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (too_big || is_self || (df_q && need_frag)) begin
					state_d = ST_OUT;
				end else begin
					state_d = ST_FRAG;
				end
			end
			ST_FRAG: begin
				csum_ctrl.clear = 1'b1;
				state_d = ST_SUM;
			end
			ST_SUM: begin
				csum_ctrl.add = 1'b1;
				if (widx_q == WIDX_LAST) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (!out_stall) begin
					state_d = last_q ? ST_IDLE : ST_FRAG;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign in_acc = in_valid & ~in_stall;
	assign out_acc = out_valid & ~out_stall;

	// Configuration registers and the identification counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_addr_q <= '0;
			device_mtu_q <= MTU_RESET;
			ident_cnt_q <= '0;
		end else begin
			if (cfg_wr && paddr[2] == REG_IDX_LOCAL_ADDR) begin
				local_addr_q <= pwdata[31:0];
			end
			if (cfg_wr && paddr[2] == REG_IDX_DEVICE_MTU) begin
				device_mtu_q <= pwdata[13:0];
			end
			if (state_q == ST_CHECK && !(too_big || is_self || (df_q && need_frag))) begin
				ident_cnt_q <= ident_cnt_q + 16'd1;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			dst_q <= dst_addr;
			proto_q <= proto;
			len_q <= payload_len;
			ttl_q <= hop_limit;
			tos_q <= {dscp_val, ecn_val};
			df_q <= dont_frag;
			limit_q <= mtu_eff - HDR_BYTES_14;
		end
		unique case (state_q)
			ST_CHECK: begin
				pos_q <= '0;
				single_q <= ~need_frag;
				ident_q <= (too_big || is_self || (df_q && need_frag)) ? 16'd0 : ident_cnt_q;
				// A rejected request leaves all fields but status and last at zero.
				if (too_big) begin
					status_q <= STATUS_TOO_LARGE;
				end else if (is_self) begin
					status_q <= STATUS_DST_SELF;
				end else begin
					status_q <= df_q && need_frag ? STATUS_NEED_FRAG_DF : STATUS_OK;
				end
				if (too_big || is_self || (df_q && need_frag)) begin
					frag_off_q <= '0;
					mf_q <= 1'b0;
					dff_q <= 1'b0;
					flen_q <= '0;
					tot_q <= '0;
					last_q <= 1'b1;
				end
			end
			ST_FRAG: begin
				widx_q <= '0;
				frag_off_q <= pos_q[15:3];
				if (single_q) begin
					flen_q <= len_q;
					mf_q <= 1'b0;
					dff_q <= df_q;
					last_q <= 1'b1;
				end else begin
					flen_q <= fits ? rem : {2'b00, chunk};
					mf_q <= ~fits;
					dff_q <= 1'b0;
					last_q <= fits;
				end
			end
			ST_SUM: begin
				widx_q <= widx_q + WIDX_W'(1);
				// The total length word is registered while word 0 is summed, before it is needed as word 1.
				if (widx_q == '0) begin
					tot_q <= flen_q + HDR_BYTES;
				end
			end
			ST_OUT: begin
				if (out_acc && !last_q) begin
					pos_q <= pos_q + flen_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign status = status_q;
	assign ident = ident_q;
	assign frag_offset = frag_off_q;
	assign more_frags = mf_q;
	assign df_flag = dff_q;
	assign payload_start = pos_q;
	assign frag_len = flen_q;
	assign total_len = tot_q;
	assign hdr_checksum = (status_q == STATUS_OK) ? csum_res : 16'd0;
	assign last = last_q;

endmodule

`default_nettype wire

[hw/rtl/iptx_csum_unit.sv]
// One's-complement accumulator that sums one header word per cycle while add is set.
`default_nettype none

module iptx_csum_unit (
	input  logic               clk,
	input  iptx_pkg::csum_ctrl_t ctrl,
	input  logic [15:0]        word,
	output logic [15:0]        result
);
	import iptx_pkg::*;

	logic [15:0] acc_q;
	logic [16:0] sum;
	logic [15:0] folded;

	// End-around carry keeps the running sum in one's-complement form.
	assign sum = {1'b0, acc_q} + {1'b0, word};
	assign folded = sum[15:0] + {15'd0, sum[16]};
	assign result = ~acc_q;

	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			acc_q <= '0;
		end else if (ctrl.add) begin
			acc_q <= folded;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/iptx_checker.sv]
// Port-level checks on the IPv4 transmit header generator, bound to its top level.
`default_nettype none

module iptx_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_stall,
	input logic                        out_valid,
	input logic [1:0]                  status,
	input logic [15:0]                 ident,
	input logic [12:0]                 frag_offset,
	input logic                        more_frags,
	input logic                        df_flag,
	input logic [15:0]                 frag_len,
	input logic [15:0]                 total_len,
	input logic                        last
);
	import iptx_pkg::*;

	// No new request is taken while a result is on offer.
	a_busy_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("request accepted while a result is pending");

	// A rejected request gives one result with zero identification.
	a_reject_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != STATUS_OK |-> last && ident == 16'd0 && frag_len == 16'd0)
		else $error("rejection result is malformed");

	// An accepted header's total length covers the 20-byte header.
	a_total_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STATUS_OK |-> total_len == frag_len + 16'd20)
		else $error("total length does not match fragment length");

	// MF is set exactly on the headers that are not the last of their request.
	a_mf_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STATUS_OK |-> more_frags != last)
		else $error("MF flag disagrees with last");

	// DF only appears on an unfragmented packet.
	a_df_whole: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && df_flag |-> last && frag_offset == 13'd0 && !more_frags)
		else $error("DF set on a fragment");

endmodule

bind ipv4_tx_fragment_header_gen iptx_checker u_iptx_checker (.*);

`default_nettype wire
